// ----- design/mqtd_pkg.sv -----
// Shared constants, codes and types of the multi-queue task dispatcher.
`default_nettype none

package mqtd_pkg;

    // Queue bank shape and field widths
    localparam int NUM_QUEUES          = 8;
    localparam int QIDX_W              = $clog2(NUM_QUEUES);
    localparam int QCNT_W              = 4;
    localparam int HANDLE_BITS         = 16;
    localparam int RND_BITS            = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 64;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((HANDLE_BITS + QIDX_W + RND_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((QIDX_W + HANDLE_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEAL  = 2'd2;

    // Request opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Push placement modes (code 3 behaves as round robin)
    localparam logic [1:0] MODE_RR     = 2'd0;
    localparam logic [1:0] MODE_LEAST  = 2'd1;
    localparam logic [1:0] MODE_RANDOM = 2'd2;

    localparam logic [QCNT_W-1:0] QUEUES_RESET = QCNT_W'(NUM_QUEUES);

    typedef enum logic [1:0] {
        STAT_PUSHED = 2'd0,
        STAT_POPPED = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } fsm_state_t;

    // Scheduler decision handed to the control logic
    typedef struct packed {
        status_t           status;
        logic [QIDX_W-1:0] queue;
    } sched_res_t;

endpackage

`default_nettype wire

// ----- design/multi_queue_task_dispatcher_top.sv -----
// Top level of the multi-queue task dispatcher: control, queue pointers, result register.
`default_nettype none

// Multi-queue task dispatcher.
// Requests come in on the s_axis group: tuser carries the opcode (push or pop),
// tdata the task handle, worker id and random value. Each request yields
// exactly one result on the m_axis group: tuser carries the status (pushed,
// popped, nothing to pop, queue full), tdata the queue index and popped handle.
// Eight FIFO queues share one single-port handle RAM; heads, tails and counts
// sit in flops so that the least-loaded and pop-steal scans see all counts.
// Timing: a request is accepted in the idle cycle, where the queue is chosen
// and the RAM written (push) or read (pop); the result state then moves the
// result into the output register once that register is free. Results reach
// m_axis from the output register, after the registered RAM read.
// The output register decouples the sides: the next request is accepted while
// a finished result still waits. If the receiver stalls with a result pending,
// the block holds the following result in its RAM read register and stops
// accepting requests until the output register frees.
// Reset (async, active low) empties all queues, zeroes the round robin
// pointer and loads the configuration defaults; RAM contents are not cleared.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only while idle (not enforced).

module multi_queue_task_dispatcher_top #(
    parameter int QUEUE_DEPTH = mqtd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [mqtd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mqtd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: task_handle[15:0], worker_id[18:16], random_value[34:19], zero pad
    input  wire logic [mqtd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: opcode
    input  wire logic                              s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: queue_num[2:0], popped_handle[18:3], zero pad
    output logic [mqtd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // tuser: status
    output logic [1:0]                             m_axis_tuser
);

    import mqtd_pkg::*;

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int OUT_PAD = OUT_TDATA_W - QIDX_W - HANDLE_BITS;

    // configuration registers
    logic [1:0]        mode_reg;
    logic [QCNT_W-1:0] qiu_reg;
    logic              steal_reg;

    // per-queue state
    logic [CNT_W-1:0] cnt_reg  [NUM_QUEUES];
    logic [CNT_W-1:0] cnt_next [NUM_QUEUES];
    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [PTR_W-1:0] head_next[NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0] tail_next[NUM_QUEUES];

    fsm_state_t state_reg;
    fsm_state_t state_next;

    sched_res_t res;
    sched_res_t res_reg;

    logic                   in_accept;
    logic                   out_load;
    logic                   in_opcode;
    logic [HANDLE_BITS-1:0] in_handle;
    logic [QIDX_W-1:0]      in_worker;
    logic [RND_BITS-1:0]    in_rnd;
    logic [PTR_W-1:0]       ptr;
    logic [PTR_W-1:0]       ptr_inc;
    logic [ADDR_W-1:0]      mem_addr;
    logic                   mem_we;
    logic                   mem_re;
    logic [HANDLE_BITS-1:0] mem_rdata;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    status_t                m_status_reg;
    logic [QIDX_W-1:0]      m_queue_reg;
    logic [HANDLE_BITS-1:0] m_handle_reg;

    // unpack request
    assign in_opcode = s_axis_tuser;
    assign in_handle = s_axis_tdata[HANDLE_BITS-1:0];
    assign in_worker = s_axis_tdata[HANDLE_BITS +: QIDX_W];
    assign in_rnd    = s_axis_tdata[HANDLE_BITS + QIDX_W +: RND_BITS];

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RR;
            qiu_reg   <= QUEUES_RESET;
            steal_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg  <= cfg_data[1:0];
                CFG_QUEUES: qiu_reg   <= cfg_data[QCNT_W-1:0];
                CFG_STEAL:  steal_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    mqtd_sched #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_sched (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .mode          (mode_reg),
        .queues_in_use (qiu_reg),
        .stealing      (steal_reg),
        .opcode        (in_opcode),
        .worker        (in_worker),
        .rnd           (in_rnd),
        .cnt           (cnt_reg),
        .res           (res)
    );

    // RAM address: queue base plus ring pointer
    always_comb
    begin
        ptr      = (res.status == STAT_PUSHED) ? tail_reg[res.queue] : head_reg[res.queue];
        ptr_inc  = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
        mem_addr = ADDR_W'(res.queue) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
        mem_we   = in_accept && (res.status == STAT_PUSHED);
        mem_re   = in_accept && (res.status == STAT_POPPED);
    end

    mqtd_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (HANDLE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (in_handle),
        .rdata (mem_rdata)
    );

    // pointer and count update on accept
    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            cnt_next[i]  = cnt_reg[i];
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end
        if (mem_we)
        begin
            tail_next[res.queue] = ptr_inc;
            cnt_next[res.queue]  = cnt_reg[res.queue] + CNT_W'(1);
        end
        else if (mem_re)
        begin
            head_next[res.queue] = ptr_inc;
            cnt_next[res.queue]  = cnt_reg[res.queue] - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // decision held for the result cycle
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res;
        end
    end

    // FSM: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_accept) state_next = S_RESULT;
            S_RESULT: if (out_load)  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // FSM: outputs
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        out_load      = (state_reg == S_RESULT) && (!m_valid_reg || m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_comb
    begin
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_status_reg <= res_reg.status;
            m_queue_reg  <= res_reg.queue;
            m_handle_reg <= (res_reg.status == STAT_POPPED) ? mem_rdata : '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, m_handle_reg, m_queue_reg};

    // Only a successful pop carries a handle
    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_POPPED)) |-> (m_handle_reg == '0))
        else $error("non-pop result carries a handle");

    // A full report means the chosen queue really is at depth
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESULT) && (res_reg.status == STAT_FULL))
            |-> (cnt_reg[res_reg.queue] == CNT_W'(QUEUE_DEPTH)))
        else $error("full status on a queue below depth");

    // Pushes and pops only touch active queues
    a_active_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == STAT_PUSHED) || (m_axis_tuser == STAT_POPPED)))
            |-> ((m_queue_reg == '0) || (QCNT_W'(m_queue_reg) < qiu_reg)))
        else $error("request served by an inactive queue");

endmodule

`default_nettype wire

// ----- design/mqtd_store.sv -----
// Task handle store: single-port synchronous RAM with registered read data.
`default_nettype none

module mqtd_store #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    localparam int ENTRIES = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [ENTRIES];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/mqtd_sched.sv -----
// Queue selection: push placement (round robin, least loaded, random) and pop scan.
`default_nettype none

module mqtd_sched #(
    parameter int QUEUE_DEPTH = mqtd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [1:0]                     mode,
    input  wire logic [mqtd_pkg::QCNT_W-1:0]    queues_in_use,
    input  wire logic                           stealing,
    input  wire logic                           opcode,
    input  wire logic [mqtd_pkg::QIDX_W-1:0]    worker,
    input  wire logic [mqtd_pkg::RND_BITS-1:0]  rnd,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt [mqtd_pkg::NUM_QUEUES],
    output mqtd_pkg::sched_res_t                res
);

    import mqtd_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // x mod 3: base 4 digits sum to the same residue
    function automatic logic [1:0] mod3_16(input logic [15:0] x);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int k = 0; k < 8; k++)
        begin
            s1 = s1 + 5'(x[2*k +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    endfunction

    // x mod 5: base 16 digits
    function automatic logic [2:0] mod5_16(input logic [15:0] x);
        logic [5:0] s1;
        logic [4:0] s2;
        logic [4:0] s3;
        logic [4:0] r;
        s1 = '0;
        for (int k = 0; k < 4; k++)
        begin
            s1 = s1 + 6'(x[4*k +: 4]);
        end
        s2 = 5'(s1[3:0]) + 5'(s1[5:4]);
        s3 = 5'(s2[3:0]) + 5'(s2[4]);
        priority if (s3 >= 5'd15)
        begin
            r = s3 - 5'd15;
        end
        else if (s3 >= 5'd10)
        begin
            r = s3 - 5'd10;
        end
        else if (s3 >= 5'd5)
        begin
            r = s3 - 5'd5;
        end
        else
        begin
            r = s3;
        end
        return r[2:0];
    endfunction

    // x mod 6 from x mod 3 and the parity of x
    function automatic logic [2:0] mod6_16(input logic [15:0] x);
        logic [1:0] r3;
        r3 = mod3_16(x);
        return (r3[0] == x[0]) ? 3'(r3) : 3'(r3) + 3'd3;
    endfunction

    // x mod 7: base 8 digits
    function automatic logic [2:0] mod7_16(input logic [15:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(x[15]);
        for (int k = 0; k < 5; k++)
        begin
            s1 = s1 + 6'(x[3*k +: 3]);
        end
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

    logic [QCNT_W-1:0] n_act;
    logic [QIDX_W-1:0] rr_reg;
    logic [QIDX_W-1:0] rr_next;
    logic [QIDX_W-1:0] rr_pick;
    logic [QCNT_W-1:0] rr_inc;
    logic [QIDX_W-1:0] least_pick;
    logic [CNT_W-1:0]  least_cnt;
    logic [QIDX_W-1:0] rand_pick;
    logic [QIDX_W-1:0] push_q;
    logic [QIDX_W-1:0] steal_q;
    logic              steal_found;
    logic              own_ok;
    logic              rr_mode;

    // Active queue count, clamped to 1..NUM_QUEUES
    always_comb
    begin
        if (queues_in_use == '0)
        begin
            n_act = QCNT_W'(1);
        end
        else if (queues_in_use > QCNT_W'(NUM_QUEUES))
        begin
            n_act = QCNT_W'(NUM_QUEUES);
        end
        else
        begin
            n_act = queues_in_use;
        end
    end

    // Round robin: stale pointer falls back to queue 0
    always_comb
    begin
        rr_pick = (QCNT_W'(rr_reg) < n_act) ? rr_reg : '0;
        rr_inc  = QCNT_W'(rr_pick) + QCNT_W'(1);
        rr_next = (rr_inc == n_act) ? '0 : rr_inc[QIDX_W-1:0];
    end

    // Least loaded, strict less-than so the lowest index wins ties
    always_comb
    begin
        least_pick = '0;
        least_cnt  = cnt[0];
        for (int i = 1; i < NUM_QUEUES; i++)
        begin
            if ((QCNT_W'(i) < n_act) && (cnt[i] < least_cnt))
            begin
                least_pick = QIDX_W'(i);
                least_cnt  = cnt[i];
            end
        end
    end

    // Random value modulo the active count
    always_comb
    begin
        unique case (n_act)
            4'd1:    rand_pick = '0;
            4'd2:    rand_pick = {2'b00, rnd[0]};
            4'd3:    rand_pick = {1'b0, mod3_16(rnd)};
            4'd4:    rand_pick = {1'b0, rnd[1:0]};
            4'd5:    rand_pick = mod5_16(rnd);
            4'd6:    rand_pick = mod6_16(rnd);
            4'd7:    rand_pick = mod7_16(rnd);
            default: rand_pick = rnd[2:0];
        endcase
    end

    always_comb
    begin
        rr_mode = 1'b0;
        unique case (mode)
            MODE_LEAST:  push_q = least_pick;
            MODE_RANDOM: push_q = rand_pick;
            default:
            begin
                push_q  = rr_pick;
                rr_mode = 1'b1;
            end
        endcase
    end

    // Pop: own queue first, then the first non-empty other active queue
    always_comb
    begin
        own_ok      = (QCNT_W'(worker) < n_act) && (cnt[worker] != '0);
        steal_found = 1'b0;
        steal_q     = worker;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (!steal_found && (QCNT_W'(i) < n_act) && (QIDX_W'(i) != worker)
                && (cnt[i] != '0))
            begin
                steal_found = 1'b1;
                steal_q     = QIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (opcode == OP_PUSH)
        begin
            res.queue  = stealing ? push_q : '0;
            res.status = (cnt[res.queue] == CNT_W'(QUEUE_DEPTH)) ? STAT_FULL : STAT_PUSHED;
        end
        else if (!stealing)
        begin
            res.queue  = '0;
            res.status = (cnt[0] != '0) ? STAT_POPPED : STAT_EMPTY;
        end
        else if (own_ok)
        begin
            res.queue  = worker;
            res.status = STAT_POPPED;
        end
        else
        begin
            res.queue  = steal_q;
            res.status = steal_found ? STAT_POPPED : STAT_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_reg <= '0;
        end
        else if (accept && (opcode == OP_PUSH) && stealing && rr_mode)
        begin
            rr_reg <= rr_next;
        end
    end

endmodule

`default_nettype wire
